// ===== hw/rtl/tpf_pkg.sv =====
// Package for the trapezoid profile follower: payload structs, register
// indexes, controller/datapath command and status types. No dependencies.
`default_nettype none
package tpf_pkg;

  localparam int unsigned CfgAddrWidth = 5;

  localparam logic [2:0] REG_ACCEL  = 3'd0;
  localparam logic [2:0] REG_SPEED  = 3'd1;
  localparam logic [2:0] REG_GAIN   = 3'd2;
  localparam logic [2:0] REG_CLIMIT = 3'd3;
  localparam logic [2:0] REG_TICK   = 3'd4;
  localparam logic [2:0] REG_FRAC   = 3'd5;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [30:0] ACCEL_RESET  = 31'd98304;
  localparam logic [30:0] SPEED_RESET  = 31'd131072;
  localparam logic [30:0] GAIN_RESET   = 31'd65536;
  localparam logic [30:0] CLIMIT_RESET = 31'd131072;
  localparam logic [15:0] TICK_RESET   = 16'd66;
  localparam logic [15:0] FRAC_RESET   = 16'd655;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] target_distance;
    logic signed [31:0] measured_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_command;
    logic               move_finished;
  } out_item_t;

  typedef struct packed {
    logic [30:0] accel_step;
    logic [30:0] speed_limit;
    logic [30:0] gain_prop;
    logic [30:0] correction_limit;
    logic [15:0] tick_period;
    logic [15:0] finish_fraction;
  } cfg_t;

  // Datapath operations, one per step issued by the controller.
  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_LOAD     = 4'd1;  // latch item, clear command
  localparam logic [3:0] DP_ST_A     = 4'd2;  // start: divider and root setup
  localparam logic [3:0] DP_ST_DIV   = 4'd3;  // one division bit
  localparam logic [3:0] DP_ST_SQRT  = 4'd4;  // one square root step
  localparam logic [3:0] DP_ST_FIN   = 4'd5;  // choose plan
  localparam logic [3:0] DP_TK_A     = 4'd6;  // dv, tolerance, measured position along the move
  localparam logic [3:0] DP_TK_B     = 4'd7;  // finish check, phase, new speed
  localparam logic [3:0] DP_TK_C     = 4'd8;  // position increment product
  localparam logic [3:0] DP_TK_D     = 4'd9;  // new position, error
  localparam logic [3:0] DP_TK_E     = 4'd10; // error magnitude
  localparam logic [3:0] DP_TK_F     = 4'd11; // correction product
  localparam logic [3:0] DP_STOP     = 4'd12;
  localparam logic [3:0] DP_ST_PRE   = 4'd13; // start: init, vmax^2, a*mag

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpf_regs.sv =====
// APB-style register file for the trapezoid profile follower.
// Depends on tpf_pkg.
`default_nettype none
module tpf_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tpf_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output tpf_pkg::cfg_t                       cfg
);
  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_step       <= tpf_pkg::ACCEL_RESET;
      cfg.speed_limit      <= tpf_pkg::SPEED_RESET;
      cfg.gain_prop        <= tpf_pkg::GAIN_RESET;
      cfg.correction_limit <= tpf_pkg::CLIMIT_RESET;
      cfg.tick_period      <= tpf_pkg::TICK_RESET;
      cfg.finish_fraction  <= tpf_pkg::FRAC_RESET;
    end else if (wr) begin
      unique case (idx)
        tpf_pkg::REG_ACCEL:  cfg.accel_step       <= pwdata[30:0];
        tpf_pkg::REG_SPEED:  cfg.speed_limit      <= pwdata[30:0];
        tpf_pkg::REG_GAIN:   cfg.gain_prop        <= pwdata[30:0];
        tpf_pkg::REG_CLIMIT: cfg.correction_limit <= pwdata[30:0];
        tpf_pkg::REG_TICK:   cfg.tick_period      <= pwdata[15:0];
        tpf_pkg::REG_FRAC:   cfg.finish_fraction  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tpf_pkg::REG_ACCEL:  prdata = {1'b0, cfg.accel_step};
      tpf_pkg::REG_SPEED:  prdata = {1'b0, cfg.speed_limit};
      tpf_pkg::REG_GAIN:   prdata = {1'b0, cfg.gain_prop};
      tpf_pkg::REG_CLIMIT: prdata = {1'b0, cfg.correction_limit};
      tpf_pkg::REG_TICK:   prdata = {16'd0, cfg.tick_period};
      tpf_pkg::REG_FRAC:   prdata = {16'd0, cfg.finish_fraction};
      default:             prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tpf_datapath.sv =====
// Datapath of the trapezoid profile follower: profile state, restoring
// divider, square root and tick arithmetic. Depends on tpf_pkg.
`default_nettype none
module tpf_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  tpf_pkg::cfg_t            cfg,
  input  tpf_pkg::in_item_t        in_item,
  input  tpf_pkg::dp_cmd_t         cmd,
  output tpf_pkg::dp_status_t      status,
  output tpf_pkg::out_item_t       result
);
  // Profile state.
  logic [31:0] expected_position, profile_speed, ramp_length, cruise_length;
  logic [31:0] target_magnitude, peak_speed;
  logic        direction_negative, halted, finished;

  // Work registers.
  logic [1:0]  opcode;
  logic [31:0] raw_target, meas_raw;
  logic [32:0] meas_along;          // signed, -m may reach 2^31
  logic [62:0] num;                 // vmax^2, dividend of the ramp division
  logic [62:0] prod_am;
  logic [63:0] rem;                 // divider partial remainder
  logic [62:0] quo;
  logic [31:0] den;                 // 2*a
  logic        a_zero;
  logic [63:0] sq_n, sq_root, sq_bit;
  logic [31:0] dv;
  logic [47:0] tol;
  logic [1:0]  phase;
  logic [32:0] vnew;
  logic [48:0] pos_prod;
  logic [33:0] err;                 // signed
  logic [32:0] emag;
  logic [63:0] corr_prod;

  logic [31:0] t_mag;
  logic        t_neg;
  logic [64:0] rem_sh;
  logic [64:0] rem_try;
  logic [64:0] sq_sum;
  logic [32:0] e_sum;
  logic [32:0] ramp_sat;
  logic [32:0] rc_sum;
  logic [33:0] tdiff;
  logic [33:0] tabs;
  logic [31:0] corr;
  logic [34:0] cmd_v;
  logic [34:0] peak_s;
  logic [34:0] cmd_cl;
  logic [34:0] cmd_sg;
  logic [31:0] cmd_out;

  localparam logic [1:0] PH_DONE = 2'd0;
  localparam logic [1:0] PH_ACC  = 2'd1;
  localparam logic [1:0] PH_CRU  = 2'd2;
  localparam logic [1:0] PH_DEC  = 2'd3;

  assign t_neg  = raw_target[31];
  assign t_mag  = t_neg ? (32'd0 - raw_target) : raw_target;
  assign rem_sh = {rem, quo[62]};
  assign rem_try = rem_sh - {33'd0, den};
  assign sq_sum = {1'b0, sq_root} + {1'b0, sq_bit};
  assign ramp_sat = (a_zero || quo > 63'hFFFF_FFFF) ? 33'h0_FFFF_FFFF
                                                    : {1'b0, quo[31:0]};
  assign rc_sum = {1'b0, ramp_length} + {1'b0, cruise_length};
  assign tdiff  = {2'b00, target_magnitude} - {meas_along[32], meas_along};
  assign tabs   = tdiff[33] ? (34'd0 - tdiff) : tdiff;
  assign corr   = (corr_prod[63:16] > {17'd0, cfg.correction_limit})
                  ? {1'b0, cfg.correction_limit} : corr_prod[47:16];
  assign peak_s = {3'd0, peak_speed};
  always_comb begin
    cmd_v = {3'd0, profile_speed} +
            (err[33] ? (35'd0 - {3'd0, corr}) : {3'd0, corr});
    if ($signed(cmd_v) > $signed(peak_s))            cmd_cl = peak_s;
    else if ($signed(cmd_v) < $signed(35'd0 - peak_s)) cmd_cl = 35'd0 - peak_s;
    else                                              cmd_cl = cmd_v;
    cmd_sg = direction_negative ? (35'd0 - cmd_cl) : cmd_cl;
    if ($signed(cmd_sg) > $signed(35'h0_7FFF_FFFF))      cmd_out = 32'h7FFF_FFFF;
    else if ($signed(cmd_sg) < $signed(35'h7_8000_0000)) cmd_out = 32'h8000_0000;
    else                                                 cmd_out = cmd_sg[31:0];
  end

  always_comb begin
    e_sum = {1'b0, expected_position} + {1'b0, pos_prod[47:16]};
    if (pos_prod[48]) e_sum = 33'h1_0000_0000;
  end

  assign status.opcode = opcode;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_position  <= '0;
      profile_speed      <= '0;
      ramp_length        <= '0;
      cruise_length      <= '0;
      target_magnitude   <= '0;
      peak_speed         <= '0;
      direction_negative <= 1'b0;
      halted             <= 1'b1;
      finished           <= 1'b1;
      opcode             <= tpf_pkg::OP_STOP;
      result             <= '0;
    end else begin
      unique case (cmd.op)
        tpf_pkg::DP_LOAD: begin
          opcode     <= in_item.opcode;
          raw_target <= in_item.target_distance;
          meas_raw   <= in_item.measured_position;
          result.speed_command <= '0;
        end
        tpf_pkg::DP_ST_PRE: begin
          halted             <= 1'b0;
          expected_position  <= '0;
          profile_speed      <= '0;
          direction_negative <= t_neg;
          target_magnitude   <= t_mag;
          finished           <= (t_mag == 32'd0);
          num     <= {32'd0, cfg.speed_limit} * {32'd0, cfg.speed_limit};
          den     <= {cfg.accel_step, 1'b0};
          a_zero  <= (cfg.accel_step == 31'd0);
          prod_am <= {32'd0, cfg.accel_step} * {31'd0, t_mag};
        end
        tpf_pkg::DP_ST_A: begin
          rem    <= '0;
          quo    <= num;
          sq_n   <= {1'b0, prod_am};
          sq_root <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
        end
        tpf_pkg::DP_ST_DIV: begin
          if (!rem_try[64]) begin
            rem <= rem_try[63:0];
            quo <= {quo[61:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[61:0], 1'b0};
          end
        end
        tpf_pkg::DP_ST_SQRT: begin
          if (sq_bit != 0) begin
            if ({1'b0, sq_n} >= sq_sum) begin
              sq_n    <= sq_n - sq_sum[63:0];
              sq_root <= (sq_root >> 1) + sq_bit;
            end else begin
              sq_root <= sq_root >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        tpf_pkg::DP_ST_FIN: begin
          if (target_magnitude == 32'd0) begin
            ramp_length   <= '0;
            cruise_length <= '0;
            peak_speed    <= '0;
          end else if ({ramp_sat, 1'b0} > {2'b00, target_magnitude}) begin
            ramp_length   <= {1'b0, target_magnitude[31:1]};
            cruise_length <= '0;
            peak_speed    <= (sq_root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                       : sq_root[31:0];
          end else begin
            ramp_length   <= ramp_sat[31:0];
            cruise_length <= target_magnitude - {ramp_sat[30:0], 1'b0};
            peak_speed    <= {1'b0, cfg.speed_limit};
          end
          result.move_finished <= finished;
        end
        tpf_pkg::DP_TK_A: begin
          dv  <= 32'(({17'd0, cfg.accel_step} * {32'd0, cfg.tick_period}) >> 16);
          tol <= ({16'd0, target_magnitude} * {32'd0, cfg.finish_fraction}) >> 16;
          meas_along <= direction_negative ? (33'd0 - {meas_raw[31], meas_raw})
                                           : {meas_raw[31], meas_raw};
        end
        tpf_pkg::DP_TK_B: begin
          if ({14'd0, tabs} <= tol) finished <= 1'b1;
          if (expected_position >= target_magnitude) begin
            phase <= PH_DONE;
            vnew  <= '0;
          end else if (expected_position < ramp_length) begin
            phase <= PH_ACC;
            vnew  <= ({1'b0, profile_speed} + {1'b0, dv} > 33'h0_FFFF_FFFF)
                     ? 33'h0_FFFF_FFFF : {1'b0, profile_speed} + {1'b0, dv};
          end else if ({1'b0, expected_position} < rc_sum) begin
            phase <= PH_CRU;
            vnew  <= {1'b0, profile_speed};
          end else begin
            phase <= PH_DEC;
            vnew  <= (profile_speed > dv) ? {1'b0, profile_speed - dv} : 33'd0;
          end
        end
        tpf_pkg::DP_TK_C: begin
          unique case (phase)
            PH_ACC:  pos_prod <= 49'((vnew - {2'b0, dv[31:1]}) * {33'd0, cfg.tick_period});
            PH_CRU:  pos_prod <= 49'(vnew * {33'd0, cfg.tick_period});
            PH_DEC:  pos_prod <= 49'((vnew + {2'b0, dv[31:1]}) * {33'd0, cfg.tick_period});
            default: pos_prod <= '0;
          endcase
        end
        tpf_pkg::DP_TK_D: begin
          if (!halted) begin
            expected_position <= e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
            profile_speed     <= vnew[31:0];
          end
          err <= {1'b0, (e_sum[32] ? 33'h0_FFFF_FFFF : e_sum)}
                 - {meas_along[32], meas_along};
        end
        tpf_pkg::DP_TK_E: begin
          emag      <= err[33] ? 33'(34'd0 - err) : err[32:0];
          corr_prod <= '0;
        end
        tpf_pkg::DP_TK_F: begin
          corr_prod <= 64'({31'd0, emag} * {33'd0, cfg.gain_prop});
        end
        tpf_pkg::DP_STOP: begin
          halted <= 1'b1;
          result.move_finished <= finished;
        end
        default: ;
      endcase
      // The command is formed on the no-op that follows the correction product.
      if (cmd.op == tpf_pkg::DP_NOP && opcode == tpf_pkg::OP_TICK) begin
        result.speed_command <= halted ? 32'd0 : cmd_out;
        result.move_finished <= finished;
      end
      if (cmd.op == tpf_pkg::DP_NOP && opcode != tpf_pkg::OP_TICK)
        result.move_finished <= finished;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tpf_ctrl.sv =====
// Controller of the trapezoid profile follower: sequences the datapath
// and runs the input and output handshakes. Depends on tpf_pkg.
`default_nettype none
module tpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  tpf_pkg::dp_status_t    status,
  output tpf_pkg::dp_cmd_t       cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_PRE  = 4'd2;
  localparam logic [3:0] S_A    = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_TA   = 4'd7;
  localparam logic [3:0] S_TB   = 4'd8;
  localparam logic [3:0] S_TC   = 4'd9;
  localparam logic [3:0] S_TD   = 4'd10;
  localparam logic [3:0] S_TE   = 4'd11;
  localparam logic [3:0] S_TF   = 4'd12;
  localparam logic [3:0] S_WR   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state, state_next;
  logic [5:0] count, count_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd.op     = tpf_pkg::DP_NOP;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = tpf_pkg::DP_LOAD;
        state_next = S_DEC;
      end
      S_DEC: begin
        priority case (status.opcode)
          tpf_pkg::OP_START: state_next = S_PRE;
          tpf_pkg::OP_TICK:  state_next = S_TA;
          tpf_pkg::OP_STOP: begin
            cmd.op = tpf_pkg::DP_STOP;
            state_next = S_OUT;
          end
          default: state_next = S_WR;
        endcase
      end
      S_PRE: begin cmd.op = tpf_pkg::DP_ST_PRE; state_next = S_A; end
      S_A: begin
        cmd.op = tpf_pkg::DP_ST_A;
        count_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = tpf_pkg::DP_ST_DIV;
        count_next = count + 6'd1;
        if (count == 6'd62) begin
          count_next = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = tpf_pkg::DP_ST_SQRT;
        count_next = count + 6'd1;
        if (count == 6'd31) state_next = S_FIN;
      end
      S_FIN: begin cmd.op = tpf_pkg::DP_ST_FIN; state_next = S_OUT; end
      S_TA: begin cmd.op = tpf_pkg::DP_TK_A; state_next = S_TB; end
      S_TB: begin cmd.op = tpf_pkg::DP_TK_B; state_next = S_TC; end
      S_TC: begin cmd.op = tpf_pkg::DP_TK_C; state_next = S_TD; end
      S_TD: begin cmd.op = tpf_pkg::DP_TK_D; state_next = S_TE; end
      S_TE: begin cmd.op = tpf_pkg::DP_TK_E; state_next = S_TF; end
      S_TF: begin cmd.op = tpf_pkg::DP_TK_F; state_next = S_WR; end
      S_WR: state_next = S_OUT;  // datapath forms the command on a no-op
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/trapezoid_profile_follower_core.sv =====
// Single-axis trapezoid profile follower. One item in flight at a time.
// Input transfer to result: a start runs a 63-step divider, then a 32-step
// square root; a tick runs the tick steps; stop and the unused opcode skip both.
// After each result transfer the controller returns to idle, where the next
// item is taken; the divider and square root loops set the pace of a start.
// Synchronous active-high reset: registers to defaults, halted and finished set.
`default_nettype none
module trapezoid_profile_follower_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  tpf_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tpf_pkg::out_item_t                    out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tpf_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  tpf_pkg::cfg_t       cfg;
  tpf_pkg::dp_cmd_t    cmd;
  tpf_pkg::dp_status_t status;

  assign pready = 1'b1;

  tpf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  tpf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  tpf_datapath u_dp (
    .clk, .rst, .cfg, .in_item(in_data), .cmd, .status, .result(out_data)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/tpf_checker.sv =====
// Port-level checker for the trapezoid profile follower, bound to the top.
// Depends on tpf_pkg.
`default_nettype none
module tpf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input tpf_pkg::out_item_t      out_data
);
  // A transfer in must not coincide with a pending result.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_no_back: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after transfer");
endmodule

bind trapezoid_profile_follower_core tpf_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

// ===== bench/tb_trapezoid_profile_follower_core.sv =====
// Self-checking testbench for the trapezoid profile follower core.
// Drives start, tick and stop transfers plus APB register writes, and checks
// every result against a behavioral predictor. Depends on tpf_pkg and the core.
`timescale 1ns / 100ps
module tb_trapezoid_profile_follower_core;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tpf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpf_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tpf_pkg::CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  trapezoid_profile_follower_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and the motion state.
  logic [31:0] m_accel, m_vmax, m_gain, m_climit, m_dt, m_frac;
  logic [31:0] m_pos, m_speed, m_ramp, m_cruise, m_tmag, m_peak;
  logic m_neg, m_halted, m_done;

  tpf_pkg::out_item_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off = 1'b0;

  typedef struct {
    logic [1:0] op;
    logic [31:0] tgt;
    logic [31:0] meas;
    logic known;
    logic [31:0] cmd;
    logic done;
  } stim_row_t;

  function automatic logic [31:0] sat32(logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void plan_move(logic [31:0] raw);
    longint t;
    logic [63:0] mag, ramp, a;
    t = longint'($signed(raw));
    mag = (t < 0) ? -t : t;
    a = m_accel;
    m_halted = 1'b0;
    m_pos = 0;
    m_speed = 0;
    m_neg = t < 0;
    m_tmag = mag[31:0];
    if (mag == 0) begin
      m_done = 1'b1;
      m_ramp = 0;
      m_cruise = 0;
      m_peak = 0;
    end else begin
      m_done = 1'b0;
      if (a == 0) ramp = 64'hFFFF_FFFF;
      else ramp = sat32((64'(m_vmax) * m_vmax) / (2 * a));
      if (2 * ramp > mag) begin
        m_ramp = mag[32:1];
        m_cruise = 0;
        m_peak = sat32(int_sqrt(a * mag));
      end else begin
        m_ramp = ramp[31:0];
        m_cruise = mag - 2 * ramp;
        m_peak = m_vmax;
      end
    end
  endfunction

  function automatic void advance_tick(logic [31:0] raw, output logic [31:0] cmd_out);
    logic [63:0] dt, dv, e, v, emag, corr, ad, tol;
    longint m, d, err, cmd, peak;
    dt = m_dt;
    dv = (64'(m_accel) * dt) >> 16;
    e = m_pos;
    v = m_speed;
    peak = longint'(m_peak);
    m = longint'($signed(raw));
    if (m_neg) m = -m;
    d = longint'(m_tmag) - m;
    ad = (d < 0) ? -d : d;
    tol = (64'(m_tmag) * m_frac) >> 16;
    if (ad <= tol) m_done = 1'b1;
    cmd_out = 0;
    if (!m_halted) begin
      if (e >= m_tmag) begin
        v = 0;
      end else if (e < m_ramp) begin
        v = sat32(v + dv);
        e = sat32(e + (((v - dv / 2) * dt) >> 16));
      end else if (e < 64'(m_ramp) + m_cruise) begin
        e = sat32(e + ((v * dt) >> 16));
      end else begin
        v = (v > dv) ? v - dv : 0;
        e = sat32(e + (((v + dv / 2) * dt) >> 16));
      end
      m_pos = e[31:0];
      m_speed = v[31:0];
      err = longint'(e) - m;
      emag = (err < 0) ? -err : err;
      corr = (emag * m_gain) >> 16;
      if (corr > m_climit) corr = m_climit;
      cmd = longint'(v) + ((err < 0) ? -longint'(corr) : longint'(corr));
      if (cmd > peak) cmd = peak;
      if (cmd < -peak) cmd = -peak;
      if (m_neg) cmd = -cmd;
      if (cmd > 64'sd2147483647) cmd = 64'sd2147483647;
      if (cmd < -64'sd2147483648) cmd = -64'sd2147483648;
      cmd_out = cmd[31:0];
    end
  endfunction

  function automatic tpf_pkg::out_item_t predict_result(tpf_pkg::in_item_t it);
    tpf_pkg::out_item_t r;
    logic [31:0] c;
    c = 0;
    if (it.opcode == tpf_pkg::OP_START) plan_move(it.target_distance);
    else if (it.opcode == tpf_pkg::OP_TICK) advance_tick(it.measured_position, c);
    else if (it.opcode == tpf_pkg::OP_STOP) m_halted = 1'b1;
    r.speed_command = c;
    r.move_finished = m_done;
    return r;
  endfunction

  task automatic model_reset();
    m_accel = tpf_pkg::ACCEL_RESET; m_vmax = tpf_pkg::SPEED_RESET;
    m_gain = tpf_pkg::GAIN_RESET; m_climit = tpf_pkg::CLIMIT_RESET;
    m_dt = tpf_pkg::TICK_RESET; m_frac = tpf_pkg::FRAC_RESET;
    m_pos = 0; m_speed = 0; m_ramp = 0; m_cruise = 0; m_tmag = 0; m_peak = 0;
    m_neg = 0; m_halted = 1'b1; m_done = 1'b1;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= tpf_pkg::CfgAddrWidth'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tpf_pkg::REG_ACCEL:  m_accel = val & 32'h7FFF_FFFF;
      tpf_pkg::REG_SPEED:  m_vmax = val & 32'h7FFF_FFFF;
      tpf_pkg::REG_GAIN:   m_gain = val & 32'h7FFF_FFFF;
      tpf_pkg::REG_CLIMIT: m_climit = val & 32'h7FFF_FFFF;
      tpf_pkg::REG_TICK:   m_dt = val & 32'hFFFF;
      tpf_pkg::REG_FRAC:   m_frac = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  // Waits for every result, then covers the start latency of the block.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Valid stays high between back-to-back items; drain lowers it.
  task automatic send_item(tpf_pkg::in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_result(it));
  endtask

  function automatic tpf_pkg::in_item_t rand_item(int start_pct);
    tpf_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    it.target_distance = $urandom;
    it.measured_position = $urandom;
    if (r < start_pct) it.opcode = tpf_pkg::OP_START;
    else if (r < 95) it.opcode = tpf_pkg::OP_TICK;
    else if (r < 98) it.opcode = tpf_pkg::OP_STOP;
    else it.opcode = 2'd3;
    if ($urandom_range(3) != 0) begin
      // Short moves so that ticks walk through every profile phase.
      it.target_distance = $signed($urandom_range(32'h0008_0000)) *
                           ($urandom_range(1) ? 1 : -1);
    end
    if ($urandom_range(2) != 0) begin
      it.measured_position = $signed($urandom_range(32'h000C_0000)) - 32'sh0002_0000;
    end
    return it;
  endfunction

  // Result side: random stall, plus one long hold-off to fill the block.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off &&
                   !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.speed_command !== expected_q[0].speed_command) begin
            $display("%0t: speed_command expected %h actual %h", $time,
                     expected_q[0].speed_command, out_data.speed_command);
            errors++;
          end
          if (out_data.move_finished !== expected_q[0].move_finished) begin
            $display("%0t: move_finished expected %b actual %b", $time,
                     expected_q[0].move_finished, out_data.move_finished);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  stim_row_t stim_table[$];

  task automatic add_row(logic [1:0] op, logic [31:0] tgt, logic [31:0] meas,
                         logic known = 1'b0, logic [31:0] cmd = 0, logic done = 0);
    stim_row_t s;
    s.op = op; s.tgt = tgt; s.meas = meas; s.known = known; s.cmd = cmd;
    s.done = done;
    stim_table.push_back(s);
  endtask

  initial begin
    #20_000_000;
    $display("[trapezoid_profile_follower_core] ERROR");
    $finish;
  end

  initial begin
    tpf_pkg::in_item_t it;
    tpf_pkg::out_item_t pr;
    int n;
    model_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Halted after reset: zero command, finished set.
    add_row(tpf_pkg::OP_TICK, 0, 32'h7FFF_FFFF, 1, 0, 1);
    add_row(tpf_pkg::OP_STOP, 0, 0, 1, 0, 1);
    add_row(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 1);
    add_row(tpf_pkg::OP_START, 0, 0, 1, 0, 1);  // zero target finishes at once
    add_row(tpf_pkg::OP_TICK, 0, 32'h8000_0000);
    add_row(tpf_pkg::OP_START, 32'h0001_0000, 0, 1, 0, 0);
    for (int i = 0; i < 6; i++) add_row(tpf_pkg::OP_TICK, 0, i * 100);
    add_row(tpf_pkg::OP_TICK, 0, 32'h0001_0000);  // within tolerance
    add_row(tpf_pkg::OP_START, 32'h8000_0000, 0, 1, 0, 0);
    add_row(tpf_pkg::OP_TICK, 0, 32'h7FFF_FFFF);
    // Measured position equals the most negative target, so the move finishes.
    add_row(tpf_pkg::OP_TICK, 0, 32'h8000_0000);
    add_row(tpf_pkg::OP_STOP, 0, 0, 1, 0, 1);
    add_row(tpf_pkg::OP_TICK, 0, 0, 1, 0, 1);
    add_row(tpf_pkg::OP_START, 32'h7FFF_FFFF, 0, 1, 0, 0);
    add_row(tpf_pkg::OP_TICK, 0, 32'hFFFF_0000);
    add_row(tpf_pkg::OP_START, 32'hFFF0_0000, 0, 1, 0, 0);
    add_row(tpf_pkg::OP_TICK, 0, 32'h0000_1000);
    add_row(tpf_pkg::OP_TICK, 0, 32'hFFFF_F000);
    foreach (stim_table[i]) begin
      it.opcode = stim_table[i].op;
      it.target_distance = stim_table[i].tgt;
      it.measured_position = stim_table[i].meas;
      send_item(it);
      pr = expected_q[$];
      if (stim_table[i].known &&
          (pr.speed_command !== stim_table[i].cmd || pr.move_finished !== stim_table[i].done))
        begin
        $display("%0t: table row %0d expected %h/%b predicted %h/%b", $time, i,
                 stim_table[i].cmd, stim_table[i].done, pr.speed_command,
                 pr.move_finished);
        errors++;
      end
    end
    drain();

    // Extreme and ordinary settings, one phase each.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(tpf_pkg::REG_ACCEL, 0); write_reg(tpf_pkg::REG_FRAC, 0);
        end
        1: begin
          write_reg(tpf_pkg::REG_ACCEL, 32'h7FFF_FFFF);
          write_reg(tpf_pkg::REG_SPEED, 32'h7FFF_FFFF);
          write_reg(tpf_pkg::REG_GAIN, 32'h7FFF_FFFF);
          write_reg(tpf_pkg::REG_CLIMIT, 32'h7FFF_FFFF);
          write_reg(tpf_pkg::REG_TICK, 32'hFFFF);
          write_reg(tpf_pkg::REG_FRAC, 32'hFFFF);
        end
        2: begin
          write_reg(tpf_pkg::REG_SPEED, 0); write_reg(tpf_pkg::REG_GAIN, 0);
          write_reg(tpf_pkg::REG_CLIMIT, 0); write_reg(tpf_pkg::REG_TICK, 1);
        end
        default: begin
          write_reg(tpf_pkg::REG_ACCEL, $urandom_range(32'h0010_0000));
          write_reg(tpf_pkg::REG_SPEED, $urandom_range(32'h0004_0000));
          write_reg(tpf_pkg::REG_GAIN, $urandom_range(32'h0004_0000));
          write_reg(tpf_pkg::REG_CLIMIT, $urandom_range(32'h0004_0000));
          write_reg(tpf_pkg::REG_TICK, $urandom_range(32'h2000, 1));
          write_reg(tpf_pkg::REG_FRAC, $urandom_range(32'h4000));
        end
      endcase
      case (ph)
        3: begin send_idle_pct = 38; recv_idle_pct = 80; end
        4: begin send_idle_pct = 80; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      n = (ph < 3) ? 60 : 275;
      if (ph == 6) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < n; k++) send_item(rand_item(k % 40 == 0 ? 100 : 8));
      drain();
    end

    if (errors == 0) begin
      $display("[trapezoid_profile_follower_core] OK");
    end else begin
      $display("[trapezoid_profile_follower_core] ERROR");
    end
    $finish;
  end
endmodule
